// ----- src/hcc_pkg.sv -----
// Package for the hit coincidence clusterer: field widths, register codes,
// reset values, result record and small helper functions.
// Depends on nothing; every other file of the block uses it.
package hcc_pkg;

  // Field widths of a hit and of a result.
  localparam int TS_W   = 32;
  localparam int CH_W   = 6;
  localparam int EN_W   = 16;
  localparam int Q_W    = 8;
  localparam int GAP_W  = 10;
  localparam int CNT_W  = 8;
  localparam int SUM_W  = 24;
  localparam int WIN_W  = 10;
  localparam int MASK_W = 64;

  // Block constants.
  localparam int CHANNELS    = 64;
  localparam int GAPS_KEPT   = 4;
  localparam int QUEUE_DEPTH = 3;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [GAP_W-1:0] GAP_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RST     = 10'd32;
  localparam logic [EN_W-1:0]  ENERGY_MIN_RST = 16'd70;
  localparam logic [CNT_W-1:0] MIN_HITS_RST   = 8'd3;
  localparam logic [Q_W-1:0]   BAD_CODE_RST   = 8'd33;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_WINDOW     = 2'd0,
    REG_ENERGY_MIN = 2'd1,
    REG_MIN_HITS   = 2'd2,
    REG_BAD_CODE   = 2'd3
  } reg_idx_e;

  // Kind of a result beat.
  typedef enum logic {
    KIND_CLUSTER = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [EN_W-1:0]  energy_min;
    logic [CNT_W-1:0] min_hits;
    logic [Q_W-1:0]   bad_code;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    kind_e                               kind;
    logic [CNT_W-1:0]                    hit_count;
    logic [SUM_W-1:0]                    energy_total;
    logic [MASK_W-1:0]                   channel_set;
    logic [TS_W-1:0]                     start_time;
    logic [GAPS_KEPT-1:0][GAP_W-1:0]     gaps;
    logic [CNT_W-1:0]                    frame_clusters;
    logic                                frame_aborted;
    logic                                last;
  } res_t;

  // One-hot channel bit; channels at or above CHANNELS set nothing.
  function automatic logic [MASK_W-1:0] chan_bit(input logic [CH_W-1:0] ch);
    logic [MASK_W-1:0] m;
    m = '0;
    if (int'(ch) < CHANNELS) begin
      m[ch] = 1'b1;
    end
    return m;
  endfunction

  // Counter increment that sticks at its maximum.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- src/hit_coincidence_clusterer_core.sv -----
// Top level of the hit coincidence clusterer: input register, cluster
// state and result builder. Depends on hcc_pkg, hcc_cfg and hcc_res_queue.
//
// Usage
//   Hits of a frame enter on the input channel (in_vld_i / in_stall_o) in
//   time order, one beat per hit; frame_end_i marks the last hit of a frame.
//   Each hit causes zero to three result beats on the output channel
//   (out_vld_o / out_stall_i): a report for a cluster that the hit closes,
//   a report for the cluster closed by the frame end, and a frame summary.
//   last_o marks the final beat caused by one hit.
//   A hit accepted at one edge is worked on in the next cycle; its result
//   beats enter the queue when the hit is taken and are shown from its head.
//   Throughput: one hit per cycle while the queue has room for its beats;
//   one beat leaves per cycle while out_stall_i is low, so a hit with several
//   results can hold the input until the three-entry result queue has room.
//   When the receiver stalls, the head beat holds and the queue fills; the
//   input register then stalls the sender. Reset empties the input register
//   and the queue, closes any cluster, clears the frame counters and loads
//   the register defaults. The user writes registers over the APB-style port
//   only while the block is idle; the block itself leaves this unchecked.
module hit_coincidence_clusterer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hcc_pkg::ADDR_W-1:0] paddr,
  input  logic [hcc_pkg::DATA_W-1:0] pwdata,
  output logic [hcc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  // Hit input
  input  logic                       in_vld_i,
  output logic                       in_stall_o,
  input  logic [hcc_pkg::TS_W-1:0]   timestamp_i,
  input  logic [hcc_pkg::CH_W-1:0]   channel_i,
  input  logic [hcc_pkg::EN_W-1:0]   energy_i,
  input  logic [hcc_pkg::Q_W-1:0]    quality_i,
  input  logic                       frame_end_i,
  // Result output
  output logic                       out_vld_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic [hcc_pkg::CNT_W-1:0]  hit_count_o,
  output logic [hcc_pkg::SUM_W-1:0]  energy_total_o,
  output logic [hcc_pkg::MASK_W-1:0] channel_set_o,
  output logic [hcc_pkg::TS_W-1:0]   start_time_o,
  output logic [hcc_pkg::GAP_W-1:0]  gap_one_o,
  output logic [hcc_pkg::GAP_W-1:0]  gap_two_o,
  output logic [hcc_pkg::GAP_W-1:0]  gap_three_o,
  output logic [hcc_pkg::GAP_W-1:0]  gap_four_o,
  output logic [hcc_pkg::CNT_W-1:0]  frame_clusters_o,
  output logic                       frame_aborted_o,
  output logic                       last_o
);

  hcc_pkg::cfg_t cfg;

  // Input register.
  logic                       in_vld_q;
  logic [hcc_pkg::TS_W-1:0]   ts_q;
  logic [hcc_pkg::CH_W-1:0]   ch_q;
  logic [hcc_pkg::EN_W-1:0]   en_q;
  logic [hcc_pkg::Q_W-1:0]    qual_q;
  logic                       fend_q;
  logic                       in_acc;
  logic                       take;

  // Cluster and frame state.
  logic                                          open_q, open_d;
  logic [hcc_pkg::TS_W-1:0]                      anchor_q, anchor_d;
  logic [hcc_pkg::TS_W-1:0]                      prev_q, prev_d;
  logic [hcc_pkg::CNT_W-1:0]                     count_q, count_d;
  logic [hcc_pkg::SUM_W-1:0]                     sum_q, sum_d;
  logic [hcc_pkg::MASK_W-1:0]                    mask_q, mask_d;
  logic [hcc_pkg::GAPS_KEPT-1:0][hcc_pkg::GAP_W-1:0] gaps_q, gaps_d;
  logic [hcc_pkg::CNT_W-1:0]                     seen_q, seen_d;
  logic                                          abort_q, abort_d;

  // Results of the hit in the input register.
  hcc_pkg::res_t [hcc_pkg::QUEUE_DEPTH-1:0] slots;
  logic [1:0]                               res_cnt;
  logic [1:0]                               free;
  logic [1:0]                               push_cnt;
  hcc_pkg::res_t                            head;

  hcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The registered hit moves on once the queue has room for all its beats.
  assign take       = in_vld_q && (res_cnt <= free);
  assign in_stall_o = in_vld_q && !take;
  assign in_acc     = in_vld_i && !in_stall_o;
  assign push_cnt   = take ? res_cnt : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ts_q   <= timestamp_i;
      ch_q   <= channel_i;
      en_q   <= energy_i;
      qual_q <= quality_i;
      fend_q <= frame_end_i;
    end
  end

  // Window test, join or restart, frame end and result building.
  always_comb begin
    logic [hcc_pkg::TS_W-1:0]    diff;
    logic [hcc_pkg::TS_W-1:0]    neg_diff;
    logic [hcc_pkg::TS_W-1:0]    win_ext;
    logic                        in_win;
    logic                        joins;
    logic [hcc_pkg::TS_W-1:0]    gap_raw;
    logic [hcc_pkg::GAP_W-1:0]   gap_sat;
    logic [hcc_pkg::SUM_W:0]     sum_ext;
    logic [hcc_pkg::SUM_W-1:0]   sum_sat;
    logic                        has_a, has_b;
    hcc_pkg::res_t               rec_a, rec_b, rec_c;
    logic [1:0]                  n;

    diff     = anchor_q - ts_q;
    neg_diff = ~diff + hcc_pkg::TS_W'(1);
    win_ext  = hcc_pkg::TS_W'(cfg.window);
    in_win   = diff[hcc_pkg::TS_W-1] ? (neg_diff < win_ext) : (diff < win_ext);
    joins    = open_q && in_win && (en_q > cfg.energy_min);

    gap_raw = ts_q - prev_q;
    gap_sat = (gap_raw > hcc_pkg::TS_W'(hcc_pkg::GAP_MAX)) ? hcc_pkg::GAP_MAX
                                                          : gap_raw[hcc_pkg::GAP_W-1:0];
    sum_ext = {1'b0, sum_q} + (hcc_pkg::SUM_W + 1)'(en_q);
    sum_sat = sum_ext[hcc_pkg::SUM_W] ? hcc_pkg::SUM_MAX : sum_ext[hcc_pkg::SUM_W-1:0];

    open_d   = open_q;
    anchor_d = anchor_q;
    prev_d   = prev_q;
    count_d  = count_q;
    sum_d    = sum_q;
    mask_d   = mask_q;
    gaps_d   = gaps_q;
    seen_d   = seen_q;
    abort_d  = abort_q;
    has_a    = 1'b0;
    has_b    = 1'b0;
    rec_a    = '0;
    rec_b    = '0;
    rec_c    = '0;

    // Cluster update; an aborted frame ignores hits until its end.
    if (!abort_q) begin
      if (joins) begin
        for (int g = 0; g < hcc_pkg::GAPS_KEPT; g++) begin
          if (count_q == hcc_pkg::CNT_W'(g + 1)) begin
            gaps_d[g] = gap_sat;
          end
        end
        count_d = hcc_pkg::sat_inc(count_q);
        sum_d   = sum_sat;
        mask_d  = mask_q | hcc_pkg::chan_bit(ch_q);
        prev_d  = ts_q;
        if (qual_q == cfg.bad_code) begin
          abort_d = 1'b1;
          open_d  = 1'b0;
        end
      end else begin
        // Close the open cluster, reporting it if large enough.
        if (open_q && (count_q >= cfg.min_hits)) begin
          has_a              = 1'b1;
          rec_a.kind         = hcc_pkg::KIND_CLUSTER;
          rec_a.hit_count    = count_q;
          rec_a.energy_total = sum_q;
          rec_a.channel_set  = mask_q;
          rec_a.start_time   = anchor_q;
          rec_a.gaps         = gaps_q;
          seen_d             = hcc_pkg::sat_inc(seen_q);
        end
        // This hit opens a new cluster.
        open_d   = 1'b1;
        anchor_d = ts_q;
        prev_d   = ts_q;
        count_d  = hcc_pkg::CNT_W'(1);
        sum_d    = hcc_pkg::SUM_W'(en_q);
        mask_d   = hcc_pkg::chan_bit(ch_q);
        gaps_d   = '0;
      end
    end

    // Frame end closes the cluster and sends the summary.
    if (fend_q) begin
      if (open_d && (count_d >= cfg.min_hits)) begin
        has_b              = 1'b1;
        rec_b.kind         = hcc_pkg::KIND_CLUSTER;
        rec_b.hit_count    = count_d;
        rec_b.energy_total = sum_d;
        rec_b.channel_set  = mask_d;
        rec_b.start_time   = anchor_d;
        rec_b.gaps         = gaps_d;
        seen_d             = hcc_pkg::sat_inc(seen_d);
      end
      rec_c.kind           = hcc_pkg::KIND_SUMMARY;
      rec_c.frame_clusters = seen_d;
      rec_c.frame_aborted  = abort_d;
      rec_c.last           = 1'b1;
      seen_d  = '0;
      abort_d = 1'b0;
      open_d  = 1'b0;
    end

    rec_a.last = !(has_b || fend_q);
    rec_b.last = !fend_q;

    // Pack the beats in order into the push slots.
    slots = '0;
    n     = 2'd0;
    if (has_a) begin
      slots[n] = rec_a;
      n        = n + 2'd1;
    end
    if (has_b) begin
      slots[n] = rec_b;
      n        = n + 2'd1;
    end
    if (fend_q) begin
      slots[n] = rec_c;
      n        = n + 2'd1;
    end
    res_cnt = n;
  end

  // State registers advance when the registered hit is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      anchor_q <= '0;
      prev_q   <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      mask_q   <= '0;
      gaps_q   <= '0;
      seen_q   <= '0;
      abort_q  <= 1'b0;
    end else if (take) begin
      open_q   <= open_d;
      anchor_q <= anchor_d;
      prev_q   <= prev_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      mask_q   <= mask_d;
      gaps_q   <= gaps_d;
      seen_q   <= seen_d;
      abort_q  <= abort_d;
    end
  end

  hcc_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (slots),
    .out_stall_i (out_stall_i),
    .out_vld_o   (out_vld_o),
    .head_o      (head),
    .free_o      (free)
  );

  // Output fields from the head of the queue.
  assign kind_o           = head.kind;
  assign hit_count_o      = head.hit_count;
  assign energy_total_o   = head.energy_total;
  assign channel_set_o    = head.channel_set;
  assign start_time_o     = head.start_time;
  assign gap_one_o        = head.gaps[0];
  assign gap_two_o        = head.gaps[1];
  assign gap_three_o      = head.gaps[2];
  assign gap_four_o       = head.gaps[3];
  assign frame_clusters_o = head.frame_clusters;
  assign frame_aborted_o  = head.frame_aborted;
  assign last_o           = head.last;

endmodule

// ----- src/hcc_cfg.sv -----
// Configuration registers of the hit coincidence clusterer behind an
// APB-style port with zero wait states.
// Depends on hcc_pkg.
module hcc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [hcc_pkg::ADDR_W-1:0] paddr,
  input  logic [hcc_pkg::DATA_W-1:0] pwdata,
  output logic [hcc_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output hcc_pkg::cfg_t             cfg_o
);

  hcc_pkg::cfg_t     cfg_q, cfg_d;
  hcc_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = hcc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        hcc_pkg::REG_WINDOW:     cfg_d.window     = pwdata[hcc_pkg::WIN_W-1:0];
        hcc_pkg::REG_ENERGY_MIN: cfg_d.energy_min = pwdata[hcc_pkg::EN_W-1:0];
        hcc_pkg::REG_MIN_HITS:   cfg_d.min_hits   = pwdata[hcc_pkg::CNT_W-1:0];
        hcc_pkg::REG_BAD_CODE:   cfg_d.bad_code   = pwdata[hcc_pkg::Q_W-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      hcc_pkg::REG_WINDOW:     prdata = hcc_pkg::DATA_W'(cfg_q.window);
      hcc_pkg::REG_ENERGY_MIN: prdata = hcc_pkg::DATA_W'(cfg_q.energy_min);
      hcc_pkg::REG_MIN_HITS:   prdata = hcc_pkg::DATA_W'(cfg_q.min_hits);
      hcc_pkg::REG_BAD_CODE:   prdata = hcc_pkg::DATA_W'(cfg_q.bad_code);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window     <= hcc_pkg::WINDOW_RST;
      cfg_q.energy_min <= hcc_pkg::ENERGY_MIN_RST;
      cfg_q.min_hits   <= hcc_pkg::MIN_HITS_RST;
      cfg_q.bad_code   <= hcc_pkg::BAD_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- src/hcc_res_queue.sv -----
// Three-entry result queue of the hit coincidence clusterer: takes up to
// three result beats in a cycle; while unstalled, one a cycle leaves its head.
// Depends on hcc_pkg.
module hcc_res_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [1:0]                             push_cnt_i,
  input  hcc_pkg::res_t [hcc_pkg::QUEUE_DEPTH-1:0] push_data_i,
  input  logic                                   out_stall_i,
  output logic                                   out_vld_o,
  output hcc_pkg::res_t                          head_o,
  output logic [1:0]                             free_o
);

  hcc_pkg::res_t [hcc_pkg::QUEUE_DEPTH-1:0] ent_q, ent_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [2:0] kept;

  assign out_vld_o = (cnt_q != 2'd0);
  assign head_o    = ent_q[0];
  assign pop       = out_vld_o && !out_stall_i;
  assign kept      = {1'b0, cnt_q} - {2'b0, pop};
  assign free_o    = 2'(3'(hcc_pkg::QUEUE_DEPTH) - kept);

  // Shift out the popped head, then append the new beats behind the rest.
  always_comb begin
    logic [2:0] src;
    logic [2:0] j;
    ent_d = ent_q;
    for (int i = 0; i < hcc_pkg::QUEUE_DEPTH; i++) begin
      src = 3'(i) + {2'b0, pop};
      j   = 3'(i) - kept;
      if (src < {1'b0, cnt_q}) begin
        ent_d[i] = ent_q[src[1:0]];
      end else if (j < {1'b0, push_cnt_i}) begin
        ent_d[i] = push_data_i[j[1:0]];
      end
    end
    cnt_d = 2'(kept + {1'b0, push_cnt_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

// ----- tb/hcc_checker.sv -----
// Checker for the hit coincidence clusterer: follows register writes, hit beats
// and result beats, predicts every result and compares it field by field.
// Depends on hcc_pkg for widths, register indexes and the result record.
module hcc_checker
  import hcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port, observed only
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  // Hit channel
  input  logic              in_vld_i,
  input  logic              in_stall_i,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [EN_W-1:0]   energy_i,
  input  logic [Q_W-1:0]    quality_i,
  input  logic              frame_end_i,
  // Result channel
  input  logic              out_vld_i,
  input  logic              out_stall_i,
  input  logic              kind_i,
  input  logic [CNT_W-1:0]  hit_count_i,
  input  logic [SUM_W-1:0]  energy_total_i,
  input  logic [MASK_W-1:0] channel_set_i,
  input  logic [TS_W-1:0]   start_time_i,
  input  logic [GAP_W-1:0]  gap_one_i,
  input  logic [GAP_W-1:0]  gap_two_i,
  input  logic [GAP_W-1:0]  gap_three_i,
  input  logic [GAP_W-1:0]  gap_four_i,
  input  logic [CNT_W-1:0]  frame_clusters_i,
  input  logic              frame_aborted_i,
  input  logic              last_i,
  // Status towards the testbench top
  output int                fail_cnt_o,
  output int                pending_o,
  output int                reports_o,
  output int                summaries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies, updated on every write beat of the configuration port.
  logic [WIN_W-1:0] win_reg;
  logic [EN_W-1:0]  emin_reg;
  logic [CNT_W-1:0] min_hits_reg;
  logic [Q_W-1:0]   bad_reg;

  // Cluster and frame state of the prediction.
  logic              clu_open;
  logic [TS_W-1:0]   anchor_ts;
  logic [TS_W-1:0]   prev_ts;
  logic [CNT_W-1:0]  clu_hits;
  logic [SUM_W-1:0]  clu_energy;
  logic [MASK_W-1:0] clu_chans;
  logic [GAP_W-1:0]  clu_gaps [GAPS_KEPT];
  logic [CNT_W-1:0]  frame_reports;
  logic              frame_abort;

  // Results of one hit, then the results still due from the block.
  res_t hit_results [$];
  res_t due_results [$];

  function automatic logic [MASK_W-1:0] chan_onehot(input logic [CH_W-1:0] ch);
    logic [MASK_W-1:0] m;
    m = '0;
    if (int'(ch) < CHANNELS) begin
      m = MASK_W'(1) << ch;
    end
    return m;
  endfunction

  task automatic clear_state();
    win_reg       = WINDOW_RST;
    emin_reg      = ENERGY_MIN_RST;
    min_hits_reg  = MIN_HITS_RST;
    bad_reg       = BAD_CODE_RST;
    clu_open      = 1'b0;
    anchor_ts     = '0;
    prev_ts       = '0;
    clu_hits      = '0;
    clu_energy    = '0;
    clu_chans     = '0;
    frame_reports = '0;
    frame_abort   = 1'b0;
    foreach (clu_gaps[j]) clu_gaps[j] = '0;
    due_results.delete();
  endtask

  task automatic open_cluster(input logic [TS_W-1:0] ts, input logic [CH_W-1:0] ch,
                              input logic [EN_W-1:0] en);
    clu_open   = 1'b1;
    anchor_ts  = ts;
    prev_ts    = ts;
    clu_hits   = CNT_W'(1);
    clu_energy = SUM_W'(en);
    clu_chans  = chan_onehot(ch);
    foreach (clu_gaps[j]) clu_gaps[j] = '0;
  endtask

  // A joining hit: gap to the previous hit saturates, count and sum saturate.
  task automatic join_cluster(input logic [TS_W-1:0] ts, input logic [CH_W-1:0] ch,
                              input logic [EN_W-1:0] en);
    logic [TS_W-1:0]  dt;
    logic [SUM_W:0]   sum;
    dt = ts - prev_ts;
    if (dt > TS_W'(GAP_MAX)) begin
      dt = TS_W'(GAP_MAX);
    end
    if (clu_hits != 0 && int'(clu_hits) - 1 < GAPS_KEPT) begin
      clu_gaps[int'(clu_hits) - 1] = dt[GAP_W-1:0];
    end
    if (clu_hits != CNT_MAX) begin
      clu_hits = clu_hits + 1'b1;
    end
    sum = {1'b0, clu_energy} + (SUM_W+1)'(en);
    clu_energy = (sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
    clu_chans  = clu_chans | chan_onehot(ch);
    prev_ts    = ts;
  endtask

  // Closing reports the cluster only when it holds enough hits.
  task automatic close_cluster();
    res_t r;
    if (!clu_open) begin
      return;
    end
    clu_open = 1'b0;
    if (clu_hits < min_hits_reg) begin
      return;
    end
    r = '0;
    r.kind         = KIND_CLUSTER;
    r.hit_count    = clu_hits;
    r.energy_total = clu_energy;
    r.channel_set  = clu_chans;
    r.start_time   = anchor_ts;
    for (int j = 0; j < 4 && j < GAPS_KEPT; j++) begin
      r.gaps[j] = clu_gaps[j];
    end
    if (frame_reports != CNT_MAX) begin
      frame_reports = frame_reports + 1'b1;
    end
    hit_results = {hit_results, r};
  endtask

  task automatic close_frame();
    res_t r;
    r = '0;
    r.kind           = KIND_SUMMARY;
    r.frame_clusters = frame_reports;
    r.frame_aborted  = frame_abort;
    frame_reports    = '0;
    frame_abort      = 1'b0;
    clu_open         = 1'b0;
    hit_results = {hit_results, r};
  endtask

  // Works out the result beats that one hit causes and queues them.
  task automatic cluster_hit(input logic [TS_W-1:0] ts, input logic [CH_W-1:0] ch,
                             input logic [EN_W-1:0] en, input logic [Q_W-1:0] q,
                             input logic fe);
    logic [TS_W-1:0] diff;
    logic [TS_W-1:0] mag;
    res_t            r;
    hit_results.delete();
    if (!frame_abort) begin
      if (!clu_open) begin
        open_cluster(ts, ch, en);
      end else begin
        diff = anchor_ts - ts;
        mag  = diff[TS_W-1] ? -diff : diff;
        if (mag < TS_W'(win_reg) && en > emin_reg) begin
          join_cluster(ts, ch, en);
          // A bad joining hit drops the cluster and mutes the frame.
          if (q == bad_reg) begin
            frame_abort = 1'b1;
            clu_open    = 1'b0;
          end
        end else begin
          close_cluster();
          open_cluster(ts, ch, en);
        end
      end
    end
    if (fe) begin
      close_cluster();
      close_frame();
    end
    for (int i = 0; i < hit_results.size(); i++) begin
      r      = hit_results[i];
      r.last = (i == hit_results.size() - 1);
      due_results = {due_results, r};
    end
  endtask

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, fname, want, got);
      fail_cnt_o++;
    end
  endtask

  // Everything is sampled at the rising edge, on the values before the edge.
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      clear_state();
      fail_cnt_o  = 0;
      reports_o   = 0;
      summaries_o = 0;
    end else begin
      // Result beat against the oldest expectation.
      if (out_vld_i && !out_stall_i) begin
        if (kind_i == KIND_SUMMARY) summaries_o++;
        else reports_o++;
        if (due_results.size() == 0) begin
          $display("%0t: result beat with no expectation waiting (kind %0d)", $time, kind_i);
          fail_cnt_o++;
        end else begin
          want = due_results.pop_front();
          compare_field("kind", want.kind, kind_i);
          compare_field("hit_count", want.hit_count, hit_count_i);
          compare_field("energy_total", want.energy_total, energy_total_i);
          compare_field("channel_set", want.channel_set, channel_set_i);
          compare_field("start_time", want.start_time, start_time_i);
          compare_field("gap_one", want.gaps[0], gap_one_i);
          compare_field("gap_two", want.gaps[1], gap_two_i);
          compare_field("gap_three", want.gaps[2], gap_three_i);
          compare_field("gap_four", want.gaps[3], gap_four_i);
          compare_field("frame_clusters", want.frame_clusters, frame_clusters_i);
          compare_field("frame_aborted", want.frame_aborted, frame_aborted_i);
          compare_field("last", want.last, last_i);
        end
      end
      // Register write beat.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_WINDOW:     win_reg      = pwdata[WIN_W-1:0];
          REG_ENERGY_MIN: emin_reg     = pwdata[EN_W-1:0];
          REG_MIN_HITS:   min_hits_reg = pwdata[CNT_W-1:0];
          REG_BAD_CODE:   bad_reg      = pwdata[Q_W-1:0];
          default: ;
        endcase
      end
      // Hit beat.
      if (in_vld_i && !in_stall_i) begin
        cluster_hit(timestamp_i, channel_i, energy_i, quality_i, frame_end_i);
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ----- tb/hit_coincidence_clusterer_core_test.sv -----
// Testbench top for the hit coincidence clusterer: clock, reset, register
// writes, hit stimulus, random stalls and the verdict.
// Depends on hcc_pkg, hcc_checker and the block hit_coincidence_clusterer_core.
module hit_coincidence_clusterer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_vld_i    = 1'b0;
  logic              in_stall_o;
  logic [TS_W-1:0]   timestamp_i = '0;
  logic [CH_W-1:0]   channel_i   = '0;
  logic [EN_W-1:0]   energy_i    = '0;
  logic [Q_W-1:0]    quality_i   = '0;
  logic              frame_end_i = 1'b0;
  logic              out_vld_o;
  logic              out_stall_i = 1'b0;
  logic              kind_o;
  logic [CNT_W-1:0]  hit_count_o;
  logic [SUM_W-1:0]  energy_total_o;
  logic [MASK_W-1:0] channel_set_o;
  logic [TS_W-1:0]   start_time_o;
  logic [GAP_W-1:0]  gap_one_o;
  logic [GAP_W-1:0]  gap_two_o;
  logic [GAP_W-1:0]  gap_three_o;
  logic [GAP_W-1:0]  gap_four_o;
  logic [CNT_W-1:0]  frame_clusters_o;
  logic              frame_aborted_o;
  logic              last_o;

  int fail_cnt;
  int pending;
  int reports;
  int summaries;

  // Stimulus bookkeeping and the register values the generator aims at.
  int hits_sent;
  int settings_used;
  int cur_win;
  int cur_emin;
  int cur_bad;
  bit tx_gaps;
  bit rx_gaps;
  int rx_hold;
  int idle_cycles;

  always #10ns clk_i = ~clk_i;

  hit_coincidence_clusterer_core u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_vld_i, .in_stall_o, .timestamp_i, .channel_i, .energy_i, .quality_i, .frame_end_i,
    .out_vld_o, .out_stall_i, .kind_o, .hit_count_o, .energy_total_o, .channel_set_o,
    .start_time_o, .gap_one_o, .gap_two_o, .gap_three_o, .gap_four_o,
    .frame_clusters_o, .frame_aborted_o, .last_o
  );

  hcc_checker u_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_vld_i, .in_stall_i(in_stall_o), .timestamp_i, .channel_i, .energy_i,
    .quality_i, .frame_end_i,
    .out_vld_i(out_vld_o), .out_stall_i, .kind_i(kind_o), .hit_count_i(hit_count_o),
    .energy_total_i(energy_total_o), .channel_set_i(channel_set_o),
    .start_time_i(start_time_o), .gap_one_i(gap_one_o), .gap_two_i(gap_two_o),
    .gap_three_i(gap_three_o), .gap_four_i(gap_four_o),
    .frame_clusters_i(frame_clusters_o), .frame_aborted_i(frame_aborted_o),
    .last_i(last_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .reports_o(reports),
    .summaries_o(summaries)
  );

  // Pause length: mostly none or short, now and then long.
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver: alternates runs of ready cycles with stalls while enabled.
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (!rx_gaps || out_stall_i) begin
      out_stall_i = 1'b0;
      rx_hold     = rx_gaps ? $urandom_range(0, 12) : 0;
    end else begin
      out_stall_i = 1'b1;
      rx_hold     = pause_len();
    end
  end

  // Watchdog on cycles in which no beat of any kind is accepted.
  always @(posedge clk_i) begin
    if ((in_vld_i && !in_stall_o) || (out_vld_o && !out_stall_i) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // One hit beat; the payload holds until the block takes it.
  task automatic push_hit(input logic [TS_W-1:0] ts, input logic [CH_W-1:0] ch,
                          input logic [EN_W-1:0] en, input logic [Q_W-1:0] q,
                          input logic fe);
    int gap;
    gap = tx_gaps ? pause_len() : 0;
    if (gap > 0) begin
      in_vld_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    timestamp_i = ts;
    channel_i   = ch;
    energy_i    = en;
    quality_i   = q;
    frame_end_i = fe;
    in_vld_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_vld_i = 1'b0;
    hits_sent++;
  endtask

  // Holds the sender until every expected result is out and the block is quiet.
  task automatic drain();
    in_vld_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Writes all four registers once the block is idle; bits above each
  // register's width carry random junk.
  task automatic configure(input int win, input int emin, input int mh, input int bad);
    drain();
    reg_write(REG_WINDOW, ((DATA_W'($urandom()) >> WIN_W) << WIN_W) | DATA_W'(win));
    reg_write(REG_ENERGY_MIN, ((DATA_W'($urandom()) >> EN_W) << EN_W) | DATA_W'(emin));
    reg_write(REG_MIN_HITS, ((DATA_W'($urandom()) >> CNT_W) << CNT_W) | DATA_W'(mh));
    reg_write(REG_BAD_CODE, ((DATA_W'($urandom()) >> Q_W) << Q_W) | DATA_W'(bad));
    cur_win  = win;
    cur_emin = emin;
    cur_bad  = bad;
    settings_used++;
  endtask

  // A frame of hits that mostly fall in the window and pass the threshold,
  // with a share of bad codes and of fully random noise beats.
  task automatic random_frame(input int len);
    logic [TS_W-1:0] ts;
    logic [EN_W-1:0] en;
    logic [Q_W-1:0]  q;
    int              r;
    ts = $urandom();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        push_hit(TS_W'($urandom()), CH_W'($urandom()), EN_W'($urandom()), Q_W'($urandom()),
                 1'($urandom_range(0, 1)));
        continue;
      end
      r = $urandom_range(0, 99);
      if (i > 0) begin
        if (r < 70) ts = ts + $urandom_range(0, cur_win);
        else if (r < 85) ts = ts + $urandom_range(0, 3);
        else if (r < 93) ts = ts - $urandom_range(0, cur_win);
        else ts = ts + $urandom_range(0, 4095);
      end
      if ($urandom_range(0, 99) < 80) begin
        en = (cur_emin == 65535) ? 16'hFFFF : EN_W'($urandom_range(cur_emin + 1, 65535));
      end else begin
        en = EN_W'($urandom_range(0, cur_emin));
      end
      q = ($urandom_range(0, 99) < 6) ? Q_W'(cur_bad) : Q_W'($urandom_range(0, 255));
      push_hit(ts, CH_W'($urandom()), en, q, i == len - 1);
    end
  endtask

  // A random phase of roughly the given number of hits.
  task automatic random_phase(input int goal);
    int start;
    start = hits_sent;
    while (hits_sent - start < goal) begin
      random_frame(($urandom_range(0, 99) < 70) ? $urandom_range(2, 6) : $urandom_range(1, 12));
      if ($urandom_range(0, 99) < 10) drain();
    end
  endtask

  initial begin
    hits_sent     = 0;
    settings_used = 1;
    cur_win       = 32;
    cur_emin      = 70;
    cur_bad       = 33;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    rx_hold       = 0;
    idle_cycles   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed hits under the reset register values.
    push_hit(32'd100, 6'd0, 16'd0, 8'd255, 1'b0);       // starter, energy untested
    push_hit(32'd110, 6'd63, 16'd71, 8'd0, 1'b0);       // just above threshold
    push_hit(32'd131, 6'd5, 16'hFFFF, 8'd0, 1'b0);      // just inside the window
    push_hit(32'd140, 6'd7, 16'd200, 8'd0, 1'b0);       // outside: report, new start
    push_hit(32'd172, 6'd8, 16'd500, 8'd0, 1'b0);       // exactly on the window
    push_hit(32'd180, 6'd9, 16'd70, 8'd0, 1'b0);        // exactly on the threshold
    push_hit(32'd170, 6'd10, 16'd90, 8'd0, 1'b0);       // backwards, gap saturates
    push_hit(32'd185, 6'd11, 16'd90, 8'd0, 1'b0);
    push_hit(32'd190, 6'd12, 16'd90, 8'd0, 1'b0);
    push_hit(32'd195, 6'd13, 16'd90, 8'd0, 1'b0);
    push_hit(32'd200, 6'd14, 16'd90, 8'd0, 1'b1);       // fifth gap dropped, frame end
    push_hit(32'hFFFF_FFFF, 6'd20, 16'd1000, 8'd33, 1'b0); // bad code on a starter
    push_hit(32'h0000_0005, 6'd21, 16'd1000, 8'd1, 1'b0);  // joins across the wrap
    push_hit(32'h0000_0006, 6'd22, 16'd1000, 8'd2, 1'b0);
    push_hit(32'h8000_0000, 6'd23, 16'd100, 8'd0, 1'b0);
    push_hit(32'h0000_0000, 6'd24, 16'd100, 8'd0, 1'b0);   // most negative difference
    push_hit(32'd3, 6'd30, 16'd300, 8'd33, 1'b0);       // bad joining hit aborts
    push_hit(32'd4, 6'd31, 16'd300, 8'd0, 1'b0);        // ignored
    push_hit(32'd5, 6'd1, 16'd300, 8'd0, 1'b1);         // summary of aborted frame
    push_hit(32'd50, 6'd2, 16'd0, 8'd0, 1'b0);
    push_hit(32'd51, 6'd3, 16'd71, 8'd33, 1'b1);        // abort and frame end together
    push_hit(32'd60, 6'd4, 16'd80, 8'd0, 1'b1);         // single-hit frame

    // Widest window and no threshold: one long cluster gathers every hit.
    configure(1023, 0, 4, 0);
    for (int i = 0; i < 12; i++) begin
      push_hit(32'h1234_5678, CH_W'($urandom()), 16'hFFFF, 8'd1, i == 11);
    end

    // Zero window and zero minimum: every hit closes a cluster that is reported.
    configure(0, 65535, 0, 255);
    for (int i = 0; i < 16; i++) begin
      push_hit(TS_W'($urandom()), CH_W'($urandom()), EN_W'($urandom()), Q_W'($urandom()),
               i == 15);
    end

    // Random phases over several register settings, one with no idling.
    configure(32, 70, 3, 33);
    random_phase(10);
    configure(1, 0, 2, 7);
    random_phase(10);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    configure(600, 30000, 2, 255);
    random_phase(10);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    configure($urandom_range(1, 1023), $urandom_range(0, 400), $urandom_range(1, 4),
              $urandom_range(0, 255));
    random_phase(10);
    configure($urandom_range(0, 200), $urandom_range(0, 65535), $urandom_range(0, 3),
              $urandom_range(0, 255));
    random_phase(10);

    drain();
    $display("Sent %0d hits under %0d register settings; checked %0d cluster reports",
             hits_sent, settings_used, reports);
    $display("and %0d frame summaries, with random idling and stalls on both channels.",
             summaries);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
